@@ src/npc_pkg.sv @@
package npc_pkg;

  // color channel, palette index and squared distance widths
  localparam int COLOR_W  = 8;
  localparam int INDEX_W  = 8;
  localparam int SQ_W     = 2 * COLOR_W;
  localparam int DIST_W   = SQ_W + 2;
  localparam int RGB_W    = 3 * COLOR_W;

  // default palette depth
  localparam int DEF_PALETTE_SIZE = 256;

  // item mode codes
  localparam logic MODE_WRITE = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  // tag that follows one palette read down the distance pipeline
  typedef struct packed {
    logic               vld;
    logic               last;
    logic [INDEX_W-1:0] idx;
  } npc_tag_t;

endpackage

@@ src/npc_store.sv @@
module npc_store
  import npc_pkg::*;
#(
  parameter int PALETTE_SIZE = DEF_PALETTE_SIZE,
  parameter int ADDR_W       = $clog2(PALETTE_SIZE)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [RGB_W-1:0]  wr_data,
  input  logic [ADDR_W-1:0] rd_addr,
  input  npc_tag_t          rd_tag,
  output logic [RGB_W-1:0]  rd_data,
  output npc_tag_t          rd_tag_out
);

  logic [RGB_W-1:0]        mem [PALETTE_SIZE];
  logic [PALETTE_SIZE-1:0] valid_r;
  logic [RGB_W-1:0]        rd_data_r;
  logic                    rd_valid_r;
  npc_tag_t                rd_tag_r;

  // palette memory, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  // written flags, an entry never written reads as black
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= '0;
      rd_valid_r <= 1'b0;
      rd_tag_r   <= '0;
    end else begin
      if (wr_en) begin
        valid_r[wr_addr] <= 1'b1;
      end
      rd_valid_r <= valid_r[rd_addr];
      rd_tag_r   <= rd_tag;
    end
  end

  assign rd_data    = rd_valid_r ? rd_data_r : '0;
  assign rd_tag_out = rd_tag_r;

endmodule

@@ src/npc_dist.sv @@
module npc_dist
  import npc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic [RGB_W-1:0]  entry,
  input  logic [RGB_W-1:0]  target,
  input  npc_tag_t          tag_in,
  output logic [DIST_W-1:0] sq_dist,
  output npc_tag_t          tag_out
);

  logic [COLOR_W-1:0] diff_r [3];
  logic [SQ_W-1:0]    sq_r   [3];
  logic [DIST_W-1:0]  dist_r;
  npc_tag_t           tag_a_r, tag_b_r, tag_c_r;
  logic [COLOR_W-1:0] ch_e   [3];
  logic [COLOR_W-1:0] ch_t   [3];

  // split packed colors into channels
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      ch_e[c] = entry[c*COLOR_W +: COLOR_W];
      ch_t[c] = target[c*COLOR_W +: COLOR_W];
    end
  end

  // absolute differences, then squares, then the sum
  always_ff @(posedge clk) begin
    for (int c = 0; c < 3; c++) begin
      diff_r[c] <= (ch_e[c] >= ch_t[c]) ? (ch_e[c] - ch_t[c]) : (ch_t[c] - ch_e[c]);
      sq_r[c]   <= diff_r[c] * diff_r[c];
    end
    dist_r <= DIST_W'(sq_r[0]) + DIST_W'(sq_r[1]) + DIST_W'(sq_r[2]);
  end

  // tag follows the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_a_r <= '0;
      tag_b_r <= '0;
      tag_c_r <= '0;
    end else begin
      tag_a_r <= tag_in;
      tag_b_r <= tag_a_r;
      tag_c_r <= tag_b_r;
    end
  end

  assign sq_dist = dist_r;
  assign tag_out = tag_c_r;

endmodule

@@ src/nearest_palette_color.sv @@
// a query's result passes the palette read, difference, square and sum registers
// the scan reads one palette entry per cycle, busy holds off new items until done
// a palette write gives no result, busy stays low
// synchronous active-low reset clears the sequencer and marks all entries black
// the result strobe lasts one cycle, the receiver cannot stall
module nearest_palette_color
  import npc_pkg::*;
#(
  parameter int PALETTE_SIZE = DEF_PALETTE_SIZE
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic               in_mode,
  input  logic [INDEX_W-1:0] in_entry_index,
  input  logic [COLOR_W-1:0] in_red,
  input  logic [COLOR_W-1:0] in_green,
  input  logic [COLOR_W-1:0] in_blue,
  output logic               out_valid,
  output logic [INDEX_W-1:0] out_best_index
);

  localparam int ADDR_W = $clog2(PALETTE_SIZE);
  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(PALETTE_SIZE - 1);

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_SCAN  = 3'b010,
    ST_DRAIN = 3'b100
  } state_t;

  state_t             state_r, state_nxt;
  logic [ADDR_W-1:0]  addr_r, addr_nxt;
  logic [RGB_W-1:0]   tgt_r;
  logic [DIST_W-1:0]  best_dist_r;
  logic [INDEX_W-1:0] best_idx_r;
  logic               first_r;
  logic               out_valid_r;
  logic [INDEX_W-1:0] out_idx_r;

  logic               accept;
  logic               wr_en;
  npc_tag_t           issue_tag;
  logic [RGB_W-1:0]   rd_data;
  npc_tag_t           rd_tag;
  logic [DIST_W-1:0]  sq_dist;
  npc_tag_t           dist_tag;
  logic               take;
  logic [INDEX_W-1:0] new_idx;

  assign busy   = (state_r != ST_IDLE);
  assign accept = start && !busy;
  assign wr_en  = accept && (in_mode == MODE_WRITE)
                  && ({1'b0, in_entry_index} < (INDEX_W + 1)'(PALETTE_SIZE));

  // read tag for the current scan address
  always_comb begin
    issue_tag.vld  = (state_r == ST_SCAN);
    issue_tag.last = (addr_r == LAST_ADDR);
    issue_tag.idx  = INDEX_W'(addr_r);
  end

  npc_store #(
    .PALETTE_SIZE (PALETTE_SIZE),
    .ADDR_W       (ADDR_W)
  ) u_store (
    .clk        (clk),
    .rst_n      (rst_n),
    .wr_en      (wr_en),
    .wr_addr    (in_entry_index[ADDR_W-1:0]),
    .wr_data    ({in_blue, in_green, in_red}),
    .rd_addr    (addr_r),
    .rd_tag     (issue_tag),
    .rd_data    (rd_data),
    .rd_tag_out (rd_tag)
  );

  npc_dist u_dist (
    .clk     (clk),
    .rst_n   (rst_n),
    .entry   (rd_data),
    .target  (tgt_r),
    .tag_in  (rd_tag),
    .sq_dist (sq_dist),
    .tag_out (dist_tag)
  );

  // strict compare keeps the lowest index on ties
  assign take    = dist_tag.vld && (first_r || (sq_dist < best_dist_r));
  assign new_idx = take ? dist_tag.idx : best_idx_r;

  // scan sequencer
  always_comb begin
    state_nxt = state_r;
    addr_nxt  = addr_r;
    unique case (state_r)
      ST_IDLE: begin
        addr_nxt = '0;
        if (accept && (in_mode == MODE_QUERY)) begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (addr_r == LAST_ADDR) begin
          state_nxt = ST_DRAIN;
        end else begin
          addr_nxt = addr_r + 1'b1;
        end
      end
      ST_DRAIN: begin
        if (dist_tag.vld && dist_tag.last) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      addr_r      <= '0;
      first_r     <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      addr_r      <= addr_nxt;
      out_valid_r <= dist_tag.vld && dist_tag.last;
      if (accept) begin
        first_r <= 1'b1;
      end else if (dist_tag.vld) begin
        first_r <= 1'b0;
      end
    end
  end

  // target color and running best
  always_ff @(posedge clk) begin
    if (accept) begin
      tgt_r <= {in_blue, in_green, in_red};
    end
    if (take) begin
      best_dist_r <= sq_dist;
      best_idx_r  <= dist_tag.idx;
    end
    if (dist_tag.vld && dist_tag.last) begin
      out_idx_r <= new_idx;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_best_index = out_idx_r;

endmodule
